[src/fsl_pkg.sv]
// shared types, constants and helpers of the fixed string line matcher
package fsl_pkg;

    // sizes
    localparam int MAX_PATTERN    = 32;
    localparam int WIN_DEPTH      = MAX_PATTERN - 1;
    localparam int PAT_IDX_BITS   = $clog2(MAX_PATTERN);
    localparam int LEN_BITS       = 6;
    localparam int OFFSET_BITS    = 32;
    localparam int PAT_REGS       = 4;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_IDX_BITS   = 3;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

    localparam logic [OFFSET_BITS-1:0] BINARY_WINDOW = OFFSET_BITS'(65536);
    localparam logic [LEN_BITS-1:0]    MAX_LEN       = LEN_BITS'(MAX_PATTERN);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_0_7   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_8_15  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_16_23 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_24_31 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_LEN   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CASE_FOLD = 3'd5;

    // result kinds
    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [7:0] CHAR_NL = 8'h0a;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef logic [7:0]             t_byte;
    typedef logic [OFFSET_BITS-1:0] t_offset;

    // one queue entry: an optional line report followed by an optional summary
    typedef struct packed {
        logic    has_line;
        logic    has_sum;
        t_offset line_start;
        t_offset line_end;
        logic    is_binary;
        logic    any_match;
        logic    too_long;
    } t_entry;

    // queue status seen by the back end
    typedef struct packed {
        logic   not_empty;
        t_entry head;
    } t_fifo_out;

    // ascii upper to lower case when folding is on
    function automatic t_byte fold(input t_byte b, input logic en);
        t_byte r;
        r = b;
        if (en && b >= 8'h41 && b <= 8'h5a) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

endpackage

[src/fsl_front.sv]
// front end: configuration, window compare, line tracking and entry build
module fsl_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  fsl_pkg::t_byte                     i_data_byte,
    input  logic                               i_last_byte,
    input  logic                               i_cfg_we,
    input  logic [fsl_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [fsl_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_fifo_full,
    output logic                               o_push,
    output fsl_pkg::t_entry                    o_entry
);
    import fsl_pkg::*;

    logic [CFG_DATA_BITS-1:0] r_pat [PAT_REGS];
    logic [LEN_BITS-1:0]      r_len;
    logic                     r_fold;

    t_byte   r_recent [WIN_DEPTH];
    t_offset r_pos;
    t_offset r_line_start;
    logic    r_line_match;
    logic    r_nul_seen;
    logic    r_file_match;
    logic    r_sat;

    logic [LEN_BITS-1:0]     v_len;
    t_byte                   v_pat [MAX_PATTERN];
    t_byte                   v_win [MAX_PATTERN];
    logic [PAT_IDX_BITS-1:0] v_idx [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]  v_ok;
    logic                    v_accept;
    logic                    v_nl;
    logic                    v_at_max;
    logic                    v_line_match;
    logic                    v_file_match;
    logic                    v_nul;
    logic                    v_sat;
    t_offset                 v_next;

    assign o_ready  = !i_fifo_full;
    assign v_accept = i_valid && o_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAT_REGS; i++) begin
                r_pat[i] <= '0;
            end
            r_len  <= '0;
            r_fold <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAT_0_7:   r_pat[0] <= i_cfg_data;
                CFG_PAT_8_15:  r_pat[1] <= i_cfg_data;
                CFG_PAT_16_23: r_pat[2] <= i_cfg_data;
                CFG_PAT_24_31: r_pat[3] <= i_cfg_data;
                CFG_PAT_LEN:   r_len    <= i_cfg_data[LEN_BITS-1:0];
                CFG_CASE_FOLD: r_fold   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pattern bytes, clamped length
    always_comb begin
        v_len = (r_len > MAX_LEN) ? MAX_LEN : r_len;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            v_pat[j] = r_pat[j / 8][8 * (j % 8) +: 8];
        end
    end

    // window compare: position k of the window holds the byte k steps back
    always_comb begin
        v_win[0] = i_data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            v_win[k] = r_recent[k - 1];
        end
        for (int k = 0; k < MAX_PATTERN; k++) begin
            v_idx[k] = PAT_IDX_BITS'(v_len - LEN_BITS'(1) - LEN_BITS'(k));
            v_ok[k]  = (LEN_BITS'(k) >= v_len) ||
                       (fold(v_win[k], r_fold) == fold(v_pat[v_idx[k]], r_fold));
        end
    end

    // per byte line and file bookkeeping
    always_comb begin
        v_nl         = (i_data_byte == CHAR_NL);
        v_at_max     = &r_pos;
        v_next       = v_at_max ? r_pos : r_pos + OFFSET_BITS'(1);
        v_sat        = r_sat || v_at_max;
        v_nul        = r_nul_seen ||
                       (i_data_byte == CHAR_NUL && !r_sat && r_pos < BINARY_WINDOW);
        v_line_match = r_line_match || (v_len == '0) ||
                       ((r_pos >= OFFSET_BITS'(v_len - LEN_BITS'(1))) && (&v_ok));
        v_file_match = r_file_match || v_line_match;
    end

    // entry for the queue
    always_comb begin
        o_entry.has_line   = v_line_match && (v_nl || i_last_byte);
        o_entry.has_sum    = i_last_byte;
        o_entry.line_start = r_line_start;
        o_entry.line_end   = v_nl ? r_pos : v_next;
        o_entry.is_binary  = v_nul;
        o_entry.any_match  = v_file_match;
        o_entry.too_long   = v_sat;
        o_push = v_accept && (o_entry.has_line || o_entry.has_sum);
    end

    // history of raw bytes, only read once enough bytes of the file arrived
    always_ff @(posedge i_clk) begin
        if (v_accept) begin
            r_recent[0] <= i_data_byte;
            for (int k = 1; k < WIN_DEPTH; k++) begin
                r_recent[k] <= r_recent[k - 1];
            end
        end
    end

    // file state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_line_start <= '0;
            r_line_match <= 1'b0;
            r_nul_seen   <= 1'b0;
            r_file_match <= 1'b0;
            r_sat        <= 1'b0;
        end else if (v_accept) begin
            if (i_last_byte) begin
                r_pos        <= '0;
                r_line_start <= '0;
                r_line_match <= 1'b0;
                r_nul_seen   <= 1'b0;
                r_file_match <= 1'b0;
                r_sat        <= 1'b0;
            end else begin
                r_pos        <= v_next;
                r_nul_seen   <= v_nul;
                r_file_match <= v_file_match;
                r_sat        <= v_sat;
                if (v_nl) begin
                    r_line_match <= 1'b0;
                    r_line_start <= v_next;
                end else begin
                    r_line_match <= v_line_match;
                end
            end
        end
    end

endmodule

[src/fsl_fifo.sv]
// short entry queue between front end and back end
module fsl_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fsl_pkg::t_entry    i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output fsl_pkg::t_fifo_out o_status
);
    import fsl_pkg::*;

    t_entry             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic [FIFO_AW:0]   n_count;

    assign o_full             = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_status.not_empty = (r_count != '0);
    assign o_status.head      = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + (FIFO_AW + 1)'(1);
            2'b01:   n_count = r_count - (FIFO_AW + 1)'(1);
            default: n_count = r_count;
        endcase
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

[src/fsl_back.sv]
// back end: turns each entry into a line report, a summary transfer, or both
module fsl_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fsl_pkg::t_fifo_out      i_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_report_kind,
    output fsl_pkg::t_offset        o_line_start,
    output fsl_pkg::t_offset        o_line_end,
    output logic                    o_is_binary,
    output logic                    o_any_match,
    output logic                    o_too_long
);
    import fsl_pkg::*;

    t_entry r_ent;
    logic   r_valid;
    logic   r_phase;

    logic v_show_line;
    logic v_done;
    logic v_xfer;

    // line report first, summary second
    always_comb begin
        v_show_line   = r_ent.has_line && !r_phase;
        v_done        = v_show_line ? !r_ent.has_sum : 1'b1;
        v_xfer        = r_valid && i_ready;
        o_pop         = i_status.not_empty && (!r_valid || (v_xfer && v_done));
        o_valid       = r_valid;
        o_report_kind = v_show_line ? KIND_LINE : KIND_SUMMARY;
        o_line_start  = v_show_line ? r_ent.line_start : '0;
        o_line_end    = v_show_line ? r_ent.line_end : '0;
        o_is_binary   = v_show_line ? 1'b0 : r_ent.is_binary;
        o_any_match   = v_show_line ? 1'b0 : r_ent.any_match;
        o_too_long    = v_show_line ? 1'b0 : r_ent.too_long;
    end

    // output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_phase <= 1'b0;
        end else if (v_xfer) begin
            if (v_done) begin
                r_valid <= 1'b0;
            end else begin
                r_phase <= 1'b1;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_status.head;
        end
    end

endmodule

[src/fixed_string_line_matcher.sv]
// top level of the fixed string line matcher
// Takes one file byte per cycle when o_ready is high; a byte is never held up by the
// compare, which checks the whole window of up to 32 bytes in the accept cycle. Each
// transfer that closes a matching line or ends a file puts one entry into a 4-entry
// queue, and the output stage drains it at one result per cycle while i_ready is high,
// so a last byte that ends a matching line gives two results (line report, then summary).
// o_ready drops only while that queue is full. Configuration is taken at once through
// i_cfg_we and applies to the next byte; line reports of a file whose summary shows
// is_binary are to be dropped by the consumer.
module fixed_string_line_matcher (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_last_byte,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_report_kind,
    output logic [31:0]                        o_line_start,
    output logic [31:0]                        o_line_end,
    output logic                               o_is_binary,
    output logic                               o_any_match,
    output logic                               o_too_long,
    input  logic                               i_cfg_we,
    input  logic [fsl_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [fsl_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import fsl_pkg::*;

    logic      w_fifo_full;
    logic      w_push;
    t_entry    w_entry;
    logic      w_pop;
    t_fifo_out w_status;

    // byte intake and classification
    fsl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fifo_full (w_fifo_full),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    // decoupling queue
    fsl_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .o_full   (w_fifo_full),
        .i_pop    (w_pop),
        .o_status (w_status)
    );

    // result output
    fsl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_status      (w_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_report_kind (o_report_kind),
        .o_line_start  (o_line_start),
        .o_line_end    (o_line_end),
        .o_is_binary   (o_is_binary),
        .o_any_match   (o_any_match),
        .o_too_long    (o_too_long)
    );

endmodule

[bench/tb_fixed_string_line_matcher.sv]
// testbench for the fixed string line matcher: directed table, random phases
`timescale 1ns / 100ps

module tb_fixed_string_line_matcher;
    import fsl_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int NUM_PHASES    = 14;
    localparam int PHASE_ITEMS   = 62;
    localparam int MAX_REPORTS   = 10;

    // indexes that decode to no register
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic    kind;
        t_offset line_start;
        t_offset line_end;
        logic    is_binary;
        logic    any_match;
        logic    too_long;
    } t_report;

    // one row of the directed table: a register write or a byte transfer
    typedef struct packed {
        logic                     is_cfg;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] cdata;
        t_byte                    b;
        logic                     last;
        logic                     typed;
        logic [1:0]               n_typed;
        t_report                  r0;
        t_report                  r1;
    } t_dir_row;

    logic                     clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [7:0]               i_data_byte = 8'h00;
    logic                     i_last_byte = 1'b0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic                     o_report_kind;
    logic [31:0]              o_line_start;
    logic [31:0]              o_line_end;
    logic                     o_is_binary;
    logic                     o_any_match;
    logic                     o_too_long;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    fixed_string_line_matcher dut (
        .i_clk         (clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_report_kind (o_report_kind),
        .o_line_start  (o_line_start),
        .o_line_end    (o_line_end),
        .o_is_binary   (o_is_binary),
        .o_any_match   (o_any_match),
        .o_too_long    (o_too_long),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // matcher model: configuration copy
    logic [CFG_DATA_BITS-1:0] pat_reg [PAT_REGS] = '{default: '0};
    logic [LEN_BITS-1:0]      pat_len = '0;
    logic                     fold_en = 1'b0;

    // matcher model: per-file state
    t_byte   hist [WIN_DEPTH] = '{default: '0};
    t_offset ofs        = '0;
    t_offset cur_start  = '0;
    logic    line_hit   = 1'b0;
    logic    nul_seen   = 1'b0;
    logic    file_hit   = 1'b0;
    logic    sat        = 1'b0;

    t_report pending_reports [$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    int      items_sent     = 0;

    // typed expectations of the byte on the input, set with its payload
    int      typed_count = -1;
    t_report typed_a = '0;
    t_report typed_b = '0;

    logic src_idle_on  = 1'b1;
    logic sink_idle_on = 1'b1;
    int   sink_hold    = 0;

    function automatic t_report line_rec(input t_offset s, input t_offset e);
        return {KIND_LINE, s, e, 1'b0, 1'b0, 1'b0};
    endfunction

    function automatic t_report sum_rec(input logic bin, input logic any, input logic tl);
        return {KIND_SUMMARY, t_offset'(0), t_offset'(0), bin, any, tl};
    endfunction

    function automatic string report_str(input t_report r);
        return $sformatf("kind=%0d start=%0d end=%0d bin=%0d any=%0d long=%0d",
                         r.kind, r.line_start, r.line_end, r.is_binary, r.any_match,
                         r.too_long);
    endfunction

    function automatic t_byte lower_case(input t_byte b);
        if (fold_en && b >= 8'h41 && b <= 8'h5a) begin
            return b | 8'h20;
        end
        return b;
    endfunction

    function automatic t_byte pat_byte(input int i);
        return pat_reg[i >> 3][8 * (i & 7) +: 8];
    endfunction

    function automatic int clamped_len();
        return (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    endfunction

    // window ending at the current byte against the pattern
    function automatic logic window_hit(input t_byte cur, input int len);
        int k;
        if (lower_case(cur) != lower_case(pat_byte(len - 1))) begin
            return 1'b0;
        end
        for (k = 1; k < len; k++) begin
            if (lower_case(hist[k - 1]) != lower_case(pat_byte(len - 1 - k))) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // advance the matcher model by one byte, giving up to two reports
    task automatic match_byte(input t_byte b, input logic last, output t_report res_a,
                              output t_report res_b, output int n);
        int      len;
        int      k;
        t_offset pos;
        t_offset nxt;
        t_report res [2];
        n = 0;
        res[0] = '0;
        res[1] = '0;
        len = clamped_len();
        pos = ofs;
        if (b == CHAR_NUL && !sat && pos < BINARY_WINDOW) begin
            nul_seen = 1'b1;
        end
        if (len == 0) begin
            line_hit = 1'b1;
        end else if (longint'(pos) + 1 >= len && window_hit(b, len)) begin
            line_hit = 1'b1;
        end
        if (line_hit) begin
            file_hit = 1'b1;
        end
        if (pos == '1) begin
            sat = 1'b1;
            nxt = pos;
        end else begin
            nxt = pos + 1'b1;
        end
        ofs = nxt;
        if (b == CHAR_NL) begin
            if (line_hit) begin
                res[n] = line_rec(cur_start, pos);
                n++;
            end
            line_hit = 1'b0;
            cur_start = nxt;
        end
        for (k = WIN_DEPTH - 1; k > 0; k--) begin
            hist[k] = hist[k - 1];
        end
        hist[0] = b;
        if (last) begin
            if (b != CHAR_NL && line_hit) begin
                res[n] = line_rec(cur_start, nxt);
                n++;
            end
            res[n] = sum_rec(nul_seen, file_hit, sat);
            n++;
            for (k = 0; k < WIN_DEPTH; k++) begin
                hist[k] = '0;
            end
            ofs = '0;
            cur_start = '0;
            line_hit = 1'b0;
            nul_seen = 1'b0;
            file_hit = 1'b0;
            sat = 1'b0;
        end
        res_a = res[0];
        res_b = res[1];
    endtask

    // check result transfers, track register writes, predict byte transfers
    always @(posedge clk) begin : check_and_predict
        t_report got;
        t_report want;
        t_report pa;
        t_report pb;
        int      pn;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = {o_report_kind, o_line_start, o_line_end, o_is_binary, o_any_match,
                       o_too_long};
                if (pending_reports.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("unexpected result: %s", report_str(got));
                    end
                    mismatch_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (got.kind !== want.kind || got.line_start !== want.line_start ||
                        got.line_end !== want.line_end || got.is_binary !== want.is_binary ||
                        got.any_match !== want.any_match || got.too_long !== want.too_long)
                    begin
                        if (mismatch_count < MAX_REPORTS) begin
                            $display("mismatch: expected %s", report_str(want));
                            $display("          actual   %s", report_str(got));
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAT_0_7, CFG_PAT_8_15, CFG_PAT_16_23, CFG_PAT_24_31: begin
                        pat_reg[i_cfg_index[1:0]] = i_cfg_data;
                    end
                    CFG_PAT_LEN: begin
                        pat_len = i_cfg_data[LEN_BITS-1:0];
                    end
                    CFG_CASE_FOLD: begin
                        fold_en = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_valid && o_ready) begin
                match_byte(i_data_byte, i_last_byte, pa, pb, pn);
                if (typed_count >= 0) begin
                    pn = typed_count;
                    pa = typed_a;
                    pb = typed_b;
                end
                if (pn > 0) begin
                    pending_reports.push_back(pa);
                end
                if (pn > 1) begin
                    pending_reports.push_back(pb);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result sink with random stall bursts
    always @(negedge clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_ready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 11) == 0) begin
            sink_hold <= $urandom_range(0, 12);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // one byte transfer, then maybe a gap
    task automatic send_byte(input t_byte b, input logic last, input int typed_n,
                             input t_report t0, input t_report t1);
        @(negedge clk);
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        typed_count <= typed_n;
        typed_a <= t0;
        typed_b <= t1;
        @(posedge clk);
        while (!o_ready) begin
            @(posedge clk);
        end
        items_sent++;
        if (src_idle_on && $urandom_range(0, 15) == 0) begin
            @(negedge clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
        end
    endtask

    // hold the sender until every expected result is in, then let the block settle
    task automatic flush_results();
        @(negedge clk);
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        i_valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                         input logic [CFG_DATA_BITS-1:0] data);
        return {1'b1, idx, data, 8'h00, 1'b0, 1'b0, 2'd0, t_report'(0), t_report'(0)};
    endfunction

    function automatic t_dir_row byte_row(input t_byte b, input logic last);
        return {1'b0, CFG_PAT_0_7, 64'h0, b, last, 1'b0, 2'd0, t_report'(0), t_report'(0)};
    endfunction

    function automatic t_dir_row chk_row(input t_byte b, input logic last,
                                         input logic [1:0] n, input t_report r0,
                                         input t_report r1);
        return {1'b0, CFG_PAT_0_7, 64'h0, b, last, 1'b1, n, r0, r1};
    endfunction

    function automatic t_byte letter_byte();
        case ($urandom_range(0, 9))
            0: return 8'h61;        // a
            1: return 8'h62;        // b
            2: return 8'h41;        // A
            3: return 8'h42;        // B
            4: return 8'h7a;        // z
            5: return 8'h5a;        // Z
            6: return 8'h40;        // just below A
            7: return 8'h5b;        // just above Z
            8: return 8'h60;        // just below a
            default: return 8'h7b;  // just above z
        endcase
    endfunction

    function automatic t_byte pattern_pick();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return letter_byte();
        if (r < 16) return CHAR_NL;
        if (r == 16) return CHAR_NUL;
        if (r == 17) return 8'hff;
        return t_byte'($urandom_range(0, 255));
    endfunction

    function automatic t_byte noise_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return letter_byte();
        if (r == 5) return CHAR_NL;
        if (r == 6) return CHAR_NUL;
        if (r == 7) return 8'hff;
        return t_byte'($urandom_range(0, 255));
    endfunction

    // mostly noise bytes, with pattern copies and newlines in between
    task automatic send_random_file();
        t_byte file_q [$];
        int    target;
        int    lc;
        int    k;
        int    r;
        t_byte b;
        target = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 40) : $urandom_range(41, 120);
        lc = clamped_len();
        while (file_q.size() < target) begin
            r = $urandom_range(0, 9);
            if (r < 3 && lc > 0) begin
                for (k = 0; k < lc; k++) begin
                    b = pat_byte(k);
                    if ((b[5] ? (b >= 8'h61 && b <= 8'h7a) : (b >= 8'h41 && b <= 8'h5a)) &&
                        $urandom_range(0, 2) == 0) begin
                        b = b ^ 8'h20;
                    end
                    if (k == lc - 1 && $urandom_range(0, 3) == 0) begin
                        b = noise_byte();
                    end
                    file_q.push_back(b);
                end
            end else if (r == 3) begin
                file_q.push_back(CHAR_NL);
            end else begin
                file_q.push_back(noise_byte());
            end
        end
        for (k = 0; k < file_q.size(); k++) begin
            send_byte(file_q[k], k == file_q.size() - 1, -1, '0, '0);
        end
    endtask

    // register settings of one random phase, extremes first
    task automatic configure_phase(input int p);
        logic [CFG_DATA_BITS-1:0] regs [PAT_REGS];
        logic [CFG_DATA_BITS-1:0] len_data;
        logic [CFG_DATA_BITS-1:0] fold_data;
        int                       len;
        int                       r;
        int                       i;
        for (i = 0; i < MAX_PATTERN; i++) begin
            regs[i / 8][8 * (i % 8) +: 8] = pattern_pick();
        end
        r = $urandom_range(0, 9);
        len = (r < 6) ? $urandom_range(1, 4) :
              (r < 8) ? $urandom_range(5, 12) : $urandom_range(13, 63);
        fold_data = {$urandom, $urandom};
        fold_data[0] = $urandom_range(0, 1);
        case (p)
            0: len = 0;
            1: begin
                len = MAX_PATTERN;
                fold_data[0] = 1'b1;
            end
            2: begin
                for (i = 0; i < PAT_REGS; i++) regs[i] = '1;
                len = 63;
            end
            3: begin
                for (i = 0; i < PAT_REGS; i++) regs[i] = '0;
                len = 1;
                fold_data[0] = 1'b0;
            end
            4: begin
                len = MAX_PATTERN + 1;
                fold_data[0] = 1'b1;
            end
            5: len = MAX_PATTERN - 1;
            default: begin
            end
        endcase
        len_data = (p == 2) ? '1 : {$urandom, $urandom};
        len_data[LEN_BITS-1:0] = LEN_BITS'(len);
        flush_results();
        write_reg(CFG_PAT_0_7, regs[0]);
        write_reg(CFG_PAT_8_15, regs[1]);
        write_reg(CFG_PAT_16_23, regs[2]);
        write_reg(CFG_PAT_24_31, regs[3]);
        write_reg(CFG_PAT_LEN, len_data);
        write_reg(CFG_CASE_FOLD, fold_data);
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                      {$urandom, $urandom});
        end
    endtask

    t_dir_row dir_tab [28];

    initial begin : stimulus
        int i;
        int p;
        int phase_start;

        // after reset the empty pattern marks every line
        dir_tab = '{
            byte_row(8'h61, 1'b0),
            chk_row(CHAR_NL, 1'b0, 2'd1, line_rec(0, 1), '0),
            chk_row(CHAR_NUL, 1'b1, 2'd2, line_rec(2, 3), sum_rec(1'b1, 1'b1, 1'b0)),
            chk_row(8'hff, 1'b1, 2'd2, line_rec(0, 1), sum_rec(1'b0, 1'b1, 1'b0)),
            chk_row(CHAR_NL, 1'b1, 2'd2, line_rec(0, 0), sum_rec(1'b0, 1'b1, 1'b0)),
            // "ab" folded, matched by "AB"
            cfg_row(CFG_PAT_0_7, 64'h6261),
            cfg_row(CFG_PAT_LEN, 64'd2),
            cfg_row(CFG_CASE_FOLD, 64'd1),
            byte_row(8'h41, 1'b0),
            byte_row(8'h42, 1'b0),
            chk_row(8'h78, 1'b1, 2'd2, line_rec(0, 3), sum_rec(1'b0, 1'b1, 1'b0)),
            // too short a file for the pattern
            chk_row(8'h61, 1'b1, 2'd1, sum_rec(1'b0, 1'b0, 1'b0), '0),
            // no folding: "AB" misses
            cfg_row(CFG_CASE_FOLD, 64'd0),
            byte_row(8'h41, 1'b0),
            byte_row(8'h42, 1'b0),
            chk_row(CHAR_NL, 1'b1, 2'd1, sum_rec(1'b0, 1'b0, 1'b0), '0),
            // NUL pattern: cleared history before the file never matches
            cfg_row(CFG_PAT_0_7, 64'h0),
            cfg_row(CFG_PAT_LEN, 64'd3),
            byte_row(CHAR_NUL, 1'b0),
            chk_row(CHAR_NUL, 1'b1, 2'd1, sum_rec(1'b1, 1'b0, 1'b0), '0),
            // pattern ending in a newline credits the line it ends
            cfg_row(CFG_PAT_0_7, 64'h0a61),
            cfg_row(CFG_PAT_LEN, 64'd2),
            byte_row(8'h61, 1'b0),
            chk_row(CHAR_NL, 1'b0, 2'd1, line_rec(0, 1), '0),
            chk_row(8'h62, 1'b1, 2'd1, sum_rec(1'b0, 1'b1, 1'b0), '0),
            // a write to an unused index changes nothing
            cfg_row(CFG_UNUSED_LO, '1),
            byte_row(8'h61, 1'b0),
            chk_row(CHAR_NL, 1'b1, 2'd2, line_rec(0, 1), sum_rec(1'b0, 1'b1, 1'b0))
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        i_rst_n <= 1'b1;

        // directed table
        for (i = 0; i < $size(dir_tab); i++) begin
            if (dir_tab[i].is_cfg) begin
                flush_results();
                write_reg(dir_tab[i].idx, dir_tab[i].cdata);
            end else begin
                send_byte(dir_tab[i].b, dir_tab[i].last,
                          dir_tab[i].typed ? int'(dir_tab[i].n_typed) : -1,
                          dir_tab[i].r0, dir_tab[i].r1);
            end
        end

        // random phases, the last three and those with p % 5 == 2 without idling
        for (p = 0; p < NUM_PHASES; p++) begin
            configure_phase(p);
            src_idle_on = !(p >= NUM_PHASES - 3 || p % 5 == 2);
            sink_idle_on = src_idle_on;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 19) == 0) begin
                    flush_results();
                end
                send_random_file();
            end
        end

        // drain and finish
        @(negedge clk);
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge clk);
        end
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/fsl_pkg.sv
src/fsl_front.sv
src/fsl_fifo.sv
src/fsl_back.sv
src/fixed_string_line_matcher.sv
bench/tb_fixed_string_line_matcher.sv
